FILE: hdl/ttw_pkg.sv
// Package for the text-mode terminal writer: field widths, character codes,
// command codes, sequencer step codes, control word layout and microcode ROM.
// Depends on nothing; used by the top level and its checker.
package ttw_pkg;

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = 16;
  localparam int POS_W      = 12;
  // Wide enough for (SCREEN_HEIGHT+1)*SCREEN_WIDTH at the largest screen.
  localparam int POS_CALC_W = 13;

  localparam int DEF_SCREEN_WIDTH  = 80;
  localparam int DEF_SCREEN_HEIGHT = 25;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_RST_FILL,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL_PRIME,
    ST_COPY,
    ST_BOT_FILL,
    ST_READ,
    ST_READ_CAP,
    ST_CLEAR,
    ST_RESULT
  } step_t;

  typedef enum logic [1:0] {
    RD_PTR_W,
    RD_PTR_W1,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_RST_BLANK,
    WR_BLANK,
    WR_COPY,
    WR_PUT
  } wr_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_CLR,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_HOME
  } cur_op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_FILL_END,
    C_COPY_END,
    C_SCROLL,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    ptr_op_t ptr_op;
    cur_op_t cur_op;
    logic    take_in;
    logic    dispatch;
    logic    load_cell;
    logic    load_out;
    cond_t   cond;
    step_t   go_step;
    step_t   alt_step;
  } ctl_word_t;

  // The microcode ROM. When the condition holds the sequencer moves to
  // go_step (or to the command's routine when dispatch is set), else alt_step.
  function automatic ctl_word_t ucode(step_t step);
    ctl_word_t cw;
    cw = '{rd_sel: RD_PTR_W, wr_sel: WR_NONE, ptr_op: PTR_HOLD, cur_op: CUR_HOLD,
           take_in: 1'b0, dispatch: 1'b0, load_cell: 1'b0, load_out: 1'b0,
           cond: C_ALWAYS, go_step: ST_IDLE, alt_step: ST_IDLE};
    unique case (step)
      ST_RST_FILL: begin
        cw.wr_sel   = WR_RST_BLANK;
        cw.ptr_op   = PTR_INC;
        cw.cond     = C_FILL_END;
        cw.go_step  = ST_IDLE;
        cw.alt_step = ST_RST_FILL;
      end
      ST_IDLE: begin
        cw.take_in  = 1'b1;
        cw.ptr_op   = PTR_CLR;
        cw.dispatch = 1'b1;
        cw.cond     = C_IN_VALID;
        cw.alt_step = ST_IDLE;
      end
      ST_PUT: begin
        cw.wr_sel   = WR_PUT;
        cw.cur_op   = CUR_PUT;
        cw.cond     = C_SCROLL;
        cw.go_step  = ST_SCROLL_PRIME;
        cw.alt_step = ST_RESULT;
      end
      ST_SCROLL_PRIME: begin
        cw.rd_sel  = RD_PTR_W;
        cw.go_step = ST_COPY;
      end
      ST_COPY: begin
        cw.wr_sel   = WR_COPY;
        cw.rd_sel   = RD_PTR_W1;
        cw.ptr_op   = PTR_INC;
        cw.cond     = C_COPY_END;
        cw.go_step  = ST_BOT_FILL;
        cw.alt_step = ST_COPY;
      end
      ST_BOT_FILL: begin
        cw.wr_sel   = WR_BLANK;
        cw.ptr_op   = PTR_INC;
        cw.cond     = C_FILL_END;
        cw.go_step  = ST_RESULT;
        cw.alt_step = ST_BOT_FILL;
      end
      ST_READ: begin
        cw.rd_sel  = RD_IDX;
        cw.go_step = ST_READ_CAP;
      end
      ST_READ_CAP: begin
        cw.load_cell = 1'b1;
        cw.go_step   = ST_RESULT;
      end
      ST_CLEAR: begin
        cw.wr_sel   = WR_BLANK;
        cw.ptr_op   = PTR_INC;
        cw.cur_op   = CUR_HOME;
        cw.cond     = C_FILL_END;
        cw.go_step  = ST_RESULT;
        cw.alt_step = ST_CLEAR;
      end
      ST_RESULT: begin
        cw.load_out = 1'b1;
        cw.cond     = C_OUT_FREE;
        cw.go_step  = ST_IDLE;
        cw.alt_step = ST_RESULT;
      end
      default: begin
        cw.go_step = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/text_mode_terminal_writer.sv
// Text-mode terminal writer: microcoded sequencer, screen memory and cursor.
// Depends on ttw_pkg for widths, codes and the microcode ROM.
//
// Usage. Commands arrive on the in_ channel (valid/ready): put character,
// read one screen cell, or clear the screen and home the cursor. Each command
// gives exactly one item on the out_ channel (valid/ready) carrying the cursor
// offset (row+1)*SCREEN_WIDTH+column and, for a read, the cell; otherwise zero.
// The cfg_ channel writes the colour byte used for characters and blanks; it
// is always ready.
// Sequencing. One item is worked on at a time. A plain put writes its cell
// and offers its result; a read fetches the cell, captures it and offers
// the result; a clear and a put that scrolls first walk the screen memory
// one cell per cycle through its single write port. The next item can be
// accepted in the same cycle in which a result is first offered.
// Reset. After rst_n is released a clearing pass fills the screen with
// grey-on-black spaces; no item is accepted during it.
// Stalls. A result waits in the output register while out_ready is low, and
// the sequencer holds before writing the next one until it has been taken.
module text_mode_terminal_writer #(
  parameter int SCREEN_WIDTH  = ttw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = ttw_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ttw_pkg::CMD_W-1:0]   in_command,
  input  logic [ttw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [ttw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ttw_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [ttw_pkg::CELL_W-1:0]  out_cell_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ttw_pkg::COLOR_W-1:0] cfg_text_color
);
  import ttw_pkg::*;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int LAST_ROW   = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(SCREEN_WIDTH);
  localparam int RW         = $clog2(SCREEN_HEIGHT);
  localparam int CMPW       = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  step_t              pc_r, pc_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [COLOR_W-1:0] color_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CELL_W-1:0]  cell_r;
  logic [CELL_W-1:0]  rd_data_r;
  logic               out_valid_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [CELL_W-1:0]  out_cell_r;

  ctl_word_t          cw;
  step_t              disp_step;
  logic               cond_true;
  logic               in_take;
  logic               out_free;
  logic               out_load;

  logic               we;
  logic [AW-1:0]      wa;
  logic [CELL_W-1:0]  wd;
  logic [AW-1:0]      ra;

  logic               is_nl, is_bs, col_last, row_last, row_inc;
  logic               put_we, scroll_need, idx_ok;
  logic [CW-1:0]      put_col, put_col_nxt;
  logic [RW-1:0]      put_row_nxt;
  logic [AW-1:0]      cur_addr;
  logic [CELL_W-1:0]  put_data;
  logic [POS_CALC_W-1:0] pos_calc;

  assign cw        = ucode(pc_r);
  assign in_ready  = cw.take_in;
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = cw.load_out && out_free;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_value = out_cell_r;

  // Put-character decode on the latched byte and the current cursor.
  always_comb begin
    is_nl    = (ch_r == CH_NEWLINE);
    is_bs    = (ch_r == CH_BACKSPACE);
    col_last = (col_r == CW'(SCREEN_WIDTH - 1));
    row_last = (row_r == RW'(SCREEN_HEIGHT - 1));
    put_we   = !is_nl && !(is_bs && (col_r == '0));
    put_col  = is_bs ? CW'(col_r - 1'b1) : col_r;
    put_data = {color_r, (is_bs ? CH_BLANK : ch_r)};
    cur_addr = AW'(int'(row_r) * SCREEN_WIDTH + int'(put_col));
    row_inc  = is_nl || (!is_bs && col_last);
    if (is_nl) begin
      put_col_nxt = '0;
    end else if (is_bs) begin
      put_col_nxt = (col_r == '0) ? col_r : put_col;
    end else begin
      put_col_nxt = col_last ? '0 : CW'(col_r + 1'b1);
    end
    scroll_need = row_inc && row_last;
    put_row_nxt = (row_inc && !row_last) ? RW'(row_r + 1'b1) : row_r;
    idx_ok      = CMPW'(idx_r) < CMPW'(CELL_COUNT);
    pos_calc    = POS_CALC_W'((int'(row_r) + 1) * SCREEN_WIDTH + int'(col_r));
  end

  always_comb begin
    unique case (in_command)
      CMD_PUT:   disp_step = ST_PUT;
      CMD_READ:  disp_step = ST_READ;
      CMD_CLEAR: disp_step = ST_CLEAR;
      default:   disp_step = ST_RESULT;
    endcase
  end

  // Sequencer: condition select, step counter and datapath controls.
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_VALID: cond_true = in_valid;
      C_FILL_END: cond_true = (ptr_r == AW'(CELL_COUNT - 1));
      C_COPY_END: cond_true = (ptr_r == AW'(LAST_ROW - 1));
      C_SCROLL:   cond_true = scroll_need;
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b1;
    endcase

    if (cond_true) begin
      pc_nxt = cw.dispatch ? disp_step : cw.go_step;
    end else begin
      pc_nxt = cw.alt_step;
    end

    unique case (cw.ptr_op)
      PTR_CLR: ptr_nxt = '0;
      PTR_INC: ptr_nxt = AW'(ptr_r + 1'b1);
      default: ptr_nxt = ptr_r;
    endcase

    unique case (cw.cur_op)
      CUR_PUT: begin
        row_nxt = put_row_nxt;
        col_nxt = put_col_nxt;
      end
      CUR_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      default: begin
        row_nxt = row_r;
        col_nxt = col_r;
      end
    endcase

    we = 1'b0;
    wa = ptr_r;
    wd = rd_data_r;
    unique case (cw.wr_sel)
      WR_RST_BLANK: begin
        we = 1'b1;
        wd = {COLOR_RESET, CH_BLANK};
      end
      WR_BLANK: begin
        we = 1'b1;
        wd = {color_r, CH_BLANK};
      end
      WR_COPY: begin
        we = 1'b1;
      end
      WR_PUT: begin
        we = put_we;
        wa = cur_addr;
        wd = put_data;
      end
      default: begin
        we = 1'b0;
      end
    endcase

    // The copy loop fetches the cell one row below the next one it writes.
    unique case (cw.rd_sel)
      RD_PTR_W:  ra = AW'(int'(ptr_r) + SCREEN_WIDTH);
      RD_PTR_W1: ra = AW'(int'(ptr_r) + SCREEN_WIDTH + 1);
      RD_IDX:    ra = AW'(CMPW'(idx_r));
      default:   ra = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_RST_FILL;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= COLOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      ptr_r <= ptr_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_valid) begin
        color_r <= cfg_text_color;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_char_code;
      idx_r  <= in_cell_index;
      cell_r <= '0;
    end else if (cw.load_cell) begin
      cell_r <= idx_ok ? rd_data_r : '0;
    end
    if (out_load) begin
      out_pos_r  <= pos_calc[POS_W-1:0];
      out_cell_r <= cell_r;
    end
  end

endmodule

FILE: hdl/ttw_checker.sv
// Port-level checker for the text-mode terminal writer, with its bind.
// Depends on ttw_pkg for field widths; attaches to text_mode_terminal_writer.
module ttw_checker #(
  parameter int SCREEN_WIDTH  = ttw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = ttw_pkg::DEF_SCREEN_HEIGHT
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [ttw_pkg::CMD_W-1:0]   in_command,
  input logic [ttw_pkg::CHAR_W-1:0]  in_char_code,
  input logic [ttw_pkg::IDX_W-1:0]   in_cell_index,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ttw_pkg::POS_W-1:0]   out_cursor_pos,
  input logic [ttw_pkg::CELL_W-1:0]  out_cell_value,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [ttw_pkg::COLOR_W-1:0] cfg_text_color
);
  import ttw_pkg::*;

  // The cursor offset only has a checkable range when it never wraps.
  localparam bit POS_FITS = ((SCREEN_HEIGHT + 1) * SCREEN_WIDTH) <= (1 << POS_W);

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_pos)
                                && $stable(out_cell_value))
    else $error("result changed or vanished while stalled");

  // Only one item is in work: the block is busy in the cycle after accepting.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  // The cursor lies on the screen, below the offset's first row of slack.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    POS_FITS && out_valid |-> (int'(out_cursor_pos) >= SCREEN_WIDTH)
      && (int'(out_cursor_pos) < (SCREEN_HEIGHT + 1) * SCREEN_WIDTH))
    else $error("cursor offset off screen");

  // Reset drops any result and starts the clearing pass.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind text_mode_terminal_writer ttw_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_ttw_checker (.*);
